// ----- hw/rtl/sht_pkg.sv -----
package sht_pkg;

  // Sizes of the default configuration
  localparam int unsigned MaxStreams  = 128;
  localparam int unsigned BucketCount = 64;
  localparam int unsigned GenBits     = 16;

  // Multiplicative hash constant
  localparam logic [31:0] HashMult = 32'd2654435761;

  // Field widths of the stream ports
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 31;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 7;
  localparam int unsigned GenW    = 16;
  localparam int unsigned LiveW   = 8;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_CREATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH,
    S_HEAD,
    S_HLOAD,
    S_WALK,
    S_CMP,
    S_MISS,
    S_POP,
    S_GEN,
    S_APPLY,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [KeyW-1:0] flow_id;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [GenW-1:0]    generation;
    logic [LiveW-1:0]   live_streams;
  } out_item_t;

endpackage

// ----- hw/rtl/sht_hash.sv -----
module sht_hash import sht_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = BucketCount,
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [KeyW-1:0] key_i,
  output logic [BW-1:0]   bucket_o
);

  logic [31:0] prod;
  logic [BW-1:0] bucket_q;

  // Multiply modulo 2^32, keep the low bucket bits
  assign prod = {1'b0, key_i} * HashMult;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bucket_q <= prod[BW-1:0];
    end
  end

  assign bucket_o = bucket_q;

endmodule

// ----- hw/rtl/sht_core.sv -----
module sht_core import sht_pkg::*; #(
  parameter int unsigned MAX_STREAMS  = MaxStreams,
  parameter int unsigned BUCKET_COUNT = BucketCount,
  parameter int unsigned GEN_BITS     = GenBits,
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  in_item_t        item_i,
  input  logic            res_free_i,
  input  logic [BW-1:0]   bucket_i,
  output logic            hash_en_o,
  output logic            idle_o,
  output logic            done_o,
  output out_item_t       res_o
);

  localparam int unsigned SW = $clog2(MAX_STREAMS);
  localparam int unsigned PW = SW + 1;
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
  localparam logic [PW-1:0] EndMark = PW'(MAX_STREAMS);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_STREAMS);

  fsm_e state_q, state_d;

  // Storage
  logic [PW-1:0]       head_mem [BUCKET_COUNT];
  logic [PW-1:0]       next_mem [MAX_STREAMS];
  logic [KeyW-1:0]     key_mem  [MAX_STREAMS];
  logic [GEN_BITS-1:0] gen_mem  [MAX_STREAMS];
  logic [SW-1:0]       free_mem [MAX_STREAMS];
  logic [BUCKET_COUNT-1:0] head_vld_q;
  logic [MAX_STREAMS-1:0]  gen_vld_q;

  // Registered read data
  logic [PW-1:0]       head_rd_q, next_rd_q;
  logic [KeyW-1:0]     key_rd_q;
  logic [GEN_BITS-1:0] gen_rd_q;
  logic [SW-1:0]       free_rd_q;

  // Item context
  op_e                 op_q;
  logic [KeyW-1:0]     key_q;
  logic [PW-1:0]       cur_q, pred_q, head_q;
  logic [CW-1:0]       steps_q;
  logic [SW-1:0]       slot_q;
  logic                alloc_q;
  status_e             status_q;
  logic [GEN_BITS-1:0] gen_q;
  logic [CW-1:0]       freed_q, fresh_q, live_q;

  logic                hit;
  logic [GEN_BITS-1:0] gen_cur, gen_new;
  logic                head_we, next_we;
  logic [BW-1:0]       head_wa;
  logic [PW-1:0]       head_wd, next_wd;
  logic [SW-1:0]       next_wa;

  assign hit     = (key_rd_q == key_q);
  assign gen_cur = gen_vld_q[slot_q] ? gen_rd_q : '0;
  assign gen_new = gen_cur + GEN_BITS'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) begin
                 state_d = (op_e'(item_i.operation) == OP_CLEAR) ? S_CLEAR : S_HASH;
               end
      S_CLEAR: state_d = S_DONE;
      S_HASH:  state_d = S_HEAD;
      S_HEAD:  state_d = S_HLOAD;
      S_HLOAD: state_d = S_WALK;
      S_WALK:  state_d = (cur_q >= EndMark || steps_q == MaxCnt) ? S_MISS : S_CMP;
      S_CMP:   state_d = hit ? S_GEN : S_WALK;
      S_MISS: begin
        if (op_q != OP_CREATE) begin
          state_d = S_DONE;
        end else if (freed_q != '0) begin
          state_d = S_POP;
        end else if (fresh_q < MaxCnt) begin
          state_d = S_GEN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP:   state_d = S_GEN;
      S_GEN:   state_d = S_APPLY;
      S_APPLY: state_d = S_DONE;
      S_DONE:  if (res_free_i) begin
                 state_d = S_IDLE;
               end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and write strobes
  always_comb begin
    hash_en_o = 1'b0;
    idle_o    = 1'b0;
    done_o    = 1'b0;
    head_we   = 1'b0;
    next_we   = 1'b0;
    head_wa   = bucket_i;
    head_wd   = next_rd_q;
    next_wa   = pred_q[SW-1:0];
    next_wd   = next_rd_q;
    case (state_q)
      S_IDLE:  idle_o = 1'b1;
      S_HASH:  hash_en_o = 1'b0;
      S_APPLY: begin
        if (alloc_q) begin
          head_we = 1'b1;
          head_wd = {1'b0, slot_q};
          next_we = 1'b1;
          next_wa = slot_q;
          next_wd = head_q;
        end else if (op_q == OP_REMOVE) begin
          head_we = (pred_q >= EndMark);
          next_we = (pred_q < EndMark);
        end
      end
      S_DONE:  done_o = res_free_i;
      default: idle_o = 1'b0;
    endcase
    if (state_q == S_IDLE) begin
      hash_en_o = start_i;
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (state_q == S_APPLY && alloc_q) begin
      key_mem[slot_q] <= key_q;
      gen_mem[slot_q] <= gen_new;
    end
    if (state_q == S_APPLY && !alloc_q && op_q == OP_REMOVE && freed_q < MaxCnt) begin
      free_mem[freed_q[SW-1:0]] <= slot_q;
    end
    if (state_q == S_HEAD) begin
      head_rd_q <= head_mem[bucket_i];
    end
    if (state_q == S_WALK) begin
      key_rd_q  <= key_mem[cur_q[SW-1:0]];
      next_rd_q <= next_mem[cur_q[SW-1:0]];
    end
    if (state_q == S_GEN) begin
      gen_rd_q <= gen_mem[slot_q];
    end
    if (state_q == S_MISS) begin
      free_rd_q <= free_mem[SW'(freed_q - CW'(1))];
    end
  end

  // Item context and walk registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q    <= op_e'(item_i.operation);
        key_q   <= item_i.flow_id;
        alloc_q <= 1'b0;
        slot_q  <= '0;
        gen_q   <= '0;
      end
      S_CLEAR: status_q <= ST_CLEARED;
      S_HLOAD: begin
        head_q  <= head_vld_q[bucket_i] ? head_rd_q : EndMark;
        cur_q   <= head_vld_q[bucket_i] ? head_rd_q : EndMark;
        pred_q  <= EndMark;
        steps_q <= '0;
      end
      S_CMP: begin
        if (hit) begin
          slot_q <= cur_q[SW-1:0];
        end else begin
          pred_q  <= cur_q;
          cur_q   <= next_rd_q;
          steps_q <= steps_q + CW'(1);
        end
      end
      S_MISS: begin
        status_q <= (op_q == OP_CREATE) ? ST_FULL : ST_NOT_FOUND;
        if (op_q == OP_CREATE && freed_q == '0 && fresh_q < MaxCnt) begin
          slot_q  <= fresh_q[SW-1:0];
          alloc_q <= 1'b1;
        end
      end
      S_POP: begin
        slot_q  <= free_rd_q;
        alloc_q <= 1'b1;
      end
      S_APPLY: begin
        if (alloc_q) begin
          status_q <= ST_CREATED;
          gen_q    <= gen_new;
        end else begin
          status_q <= (op_q == OP_REMOVE) ? ST_REMOVED : ST_FOUND;
          gen_q    <= gen_cur;
        end
      end
      default: ;
    endcase
  end

  // Control state: sequencer, counters, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_vld_q <= '0;
      gen_vld_q  <= '0;
      freed_q    <= '0;
      fresh_q    <= '0;
      live_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: begin
          head_vld_q <= '0;
          freed_q    <= '0;
          fresh_q    <= '0;
          live_q     <= '0;
        end
        S_MISS: begin
          if (op_q == OP_CREATE && freed_q == '0 && fresh_q < MaxCnt) begin
            fresh_q <= fresh_q + CW'(1);
          end
        end
        S_POP: freed_q <= freed_q - CW'(1);
        S_APPLY: begin
          if (head_we) begin
            head_vld_q[head_wa] <= 1'b1;
          end
          if (alloc_q) begin
            gen_vld_q[slot_q] <= 1'b1;
            live_q            <= live_q + CW'(1);
          end else if (op_q == OP_REMOVE) begin
            if (freed_q < MaxCnt) begin
              freed_q <= freed_q + CW'(1);
            end
            if (live_q != '0) begin
              live_q <= live_q - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result: slot and generation only where a slot is involved
  always_comb begin
    res_o.status       = status_q;
    res_o.slot         = '0;
    res_o.generation   = '0;
    res_o.live_streams = LiveW'(live_q);
    if (status_q == ST_FOUND || status_q == ST_CREATED || status_q == ST_REMOVED) begin
      res_o.slot       = SlotW'(slot_q);
      res_o.generation = GenW'(gen_q);
    end
  end

endmodule

// ----- hw/rtl/stream_id_hash_table.sv -----
// Stream identifier hash table.
// Input channel in_valid_i / in_stall_o carries one operation (lookup,
// get-or-create, remove, clear) with a 31-bit stream id. Every operation
// gives exactly one result on out_valid_o / out_stall_i: status, slot,
// slot generation and the live stream count after the operation.
// One operation at a time: in_stall_o is high from the transfer until the
// result is loaded into the output register; the next transfer can be taken
// in the following cycle.
// Clear goes from its clear step straight to the result. Other operations
// hash the id, read and load the bucket head, then visit chain entries (key
// and link memory read, then compare); creating a never-used slot adds a
// miss step, and popping a freed slot adds a miss step and a pop step.
// The chain walk over the single key/link memory port sets the rate.
// A result waits in the output register while out_stall_i is high; the
// next operation may be taken meanwhile but its result waits for the
// register to drain.
// Reset empties all buckets, clears every generation to zero, empties the free
// slot pool and makes every slot never-used again; no sweep is needed.
module stream_id_hash_table import sht_pkg::*; #(
  parameter int unsigned MAX_STREAMS  = MaxStreams,
  parameter int unsigned BUCKET_COUNT = BucketCount,
  parameter int unsigned GEN_BITS     = GenBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic            idle, done, hash_en, start;
  logic [BW-1:0]   bucket;
  out_item_t       res;
  logic            out_valid_q;
  out_item_t       out_data_q;

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;

  sht_hash #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_hash (
    .clk_i    (clk_i),
    .en_i     (hash_en),
    .key_i    (in_data_i.flow_id),
    .bucket_o (bucket)
  );

  sht_core #(
    .MAX_STREAMS (MAX_STREAMS),
    .BUCKET_COUNT(BUCKET_COUNT),
    .GEN_BITS    (GEN_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_data_i),
    .res_free_i (!out_valid_q),
    .bucket_i   (bucket),
    .hash_en_o  (hash_en),
    .idle_o     (idle),
    .done_o     (done),
    .res_o      (res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/sht_checker.sv -----
module sht_checker import sht_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // One operation in flight: busy right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an operation is in flight");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // Status codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= ST_CLEARED))
    else $error("status out of range");

  // No slot reported where none is involved
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_NOT_FOUND || out_data_o.status == ST_FULL
                     || out_data_o.status == ST_CLEARED))
    |-> (out_data_o.slot == '0 && out_data_o.generation == '0))
    else $error("slot reported without a slot");

  // Clear leaves no live streams
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_CLEARED) |-> (out_data_o.live_streams == '0))
    else $error("clear left live streams");

endmodule

bind stream_id_hash_table sht_checker u_sht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
